@@ hdl/lcbt_pkg.sv @@
// ---------------------------------------------------------------------------
// lcbt_pkg: shared types and constants of the linear complexity tester
// Field widths, histogram size, reset values and the result record that the
// histogram unit hands to the top level.
// ---------------------------------------------------------------------------
package lcbt_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int LC_W      = 13;
    localparam int CAT_W     = 3;
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 13;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 48;

    // Histogram geometry and saturation limit.
    localparam int              NUM_BINS  = 7;
    localparam logic [CAT_W-1:0] CAT_TOP  = 3'd6;
    localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

    // Block length after reset.
    localparam logic [CFG_W-1:0] LEN_RESET = 13'd500;

    // Result of one finished block, as seen after its histogram update.
    typedef struct packed {
        logic [CAT_W-1:0] category;
        logic [CNT_W-1:0] category_count;
        logic [CNT_W-1:0] blocks_done;
    } hist_res_t;

endpackage

@@ hdl/linear_complexity_block_tester.sv @@
// ---------------------------------------------------------------------------
// linear_complexity_block_tester: Berlekamp-Massey block complexity tester
// Runs binary Berlekamp-Massey one bit at a time on fixed-length blocks and
// keeps a seven-bin histogram of the resulting linear complexities.
// ---------------------------------------------------------------------------
// Each accepted bit is worked one polynomial coefficient per cycle through
// single-bit memories: the discrepancy runs over min(L, n) coefficients and,
// when it is one, the polynomial update over max(deg C, shift + deg B)
// coefficients, between the accept, decide and advance steps, where L is the
// current complexity and n the bit's place in the block. The last bit of a
// block then hands its result to the output register, and waits there while
// an earlier result beat is still stalled. The serial coefficient loop over
// the polynomial banks limits the bit rate: a new bit is taken only once
// the last one is done. A block of N bits ends with one result beat holding
// the complexity, its bin, the bin count and the block count; counts
// saturate at 65535. Bits left over in a partial block are never tested,
// and a write of the block length restarts the current block while keeping
// the counts. Lengths below 2 act as 2, above MAX_BLOCK as MAX_BLOCK. No
// clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module linear_complexity_block_tester #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: block_length.
    input  logic                          cfg_wr_en,
    input  logic [lcbt_pkg::CFG_W-1:0]    cfg_wr_data,
    // Input beats. s_tdata: [0] bit_value, rest zero.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcbt_pkg::S_DATA_W-1:0] s_tdata,
    // Result beats. m_tdata: [12:0] complexity, [15:13] category,
    // [31:16] category_count, [47:32] blocks_done.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lcbt_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_BLOCK + 1);
    localparam int HW = $clog2(MAX_BLOCK);
    localparam int CW = 14;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DISC   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_ADV    = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [lcbt_pkg::CFG_W-1:0] len_cfg_reg;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] lc_reg, lc_next;
    logic [AW-1:0] shift_reg, shift_next;
    logic [AW-1:0] hi_reg [3];
    logic [AW-1:0] hi_next [3];
    logic [1:0]    c_sel_reg, c_sel_next, b_sel_reg, b_sel_next, s_sel_reg, s_sel_next;
    logic [AW-1:0] idx_reg, idx_next, lim_reg, lim_next, top_reg, top_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic          acc_reg, acc_next, rd_v_reg, rd_v_next;
    logic          c_mask_reg, c_mask_next, b_valid_reg, b_valid_next, b_one_reg, b_one_next;
    logic          m_tvalid_reg;
    logic [lcbt_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [CW-1:0] cfg_ext, len_ext;
    logic [AW-1:0] len_used;
    logic          restart, hist_strobe;
    logic [AW-1:0] c_addr, b_addr;
    logic          poly_we, poly_wbit;
    logic [AW-1:0] bank_raddr [3];
    logic          bank_rdata [3];
    logic          h_we;
    logic [HW-1:0] h_waddr, h_raddr;
    logic          h_rdata;
    logic          c_rd, b_rd;
    logic [AW:0]   sum_b;
    logic [AW-1:0] top_calc;
    logic [AW-1:0] b_off;
    lcbt_pkg::hist_res_t hres;

    // Effective block length, clamped to the supported range.
    always_comb begin
        cfg_ext = CW'(len_cfg_reg);
        if (cfg_ext < CW'(2)) begin
            len_ext = CW'(2);
        end else if (cfg_ext > CW'(MAX_BLOCK)) begin
            len_ext = CW'(MAX_BLOCK);
        end else begin
            len_ext = cfg_ext;
        end
        len_used = len_ext[AW-1:0];
    end

    // Polynomial banks: one holds C, one B, the third takes the new C.
    for (genvar k = 0; k < 3; k++) begin : g_bank
        lcbt_ram #(.WIDTH(1), .DEPTH(2 ** AW)) u_bank (
            .aclk  (aclk),
            .we    (poly_we && (s_sel_reg == 2'(k))),
            .waddr (wr_idx_reg),
            .wdata (poly_wbit),
            .raddr (bank_raddr[k]),
            .rdata (bank_rdata[k])
        );
        assign bank_raddr[k] = (c_sel_reg == 2'(k)) ? c_addr : b_addr;
    end

    // Bits of the current block.
    lcbt_ram #(.WIDTH(1), .DEPTH(2 ** HW)) u_hist_mem (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (s_tdata[0]),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    lcbt_hist #(.AW(AW)) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (1'b0),
        .strobe  (hist_strobe),
        .len     (len_used),
        .lc      (lc_reg),
        .res     (hres)
    );

    assign c_rd      = bank_rdata[c_sel_reg];
    assign b_rd      = bank_rdata[b_sel_reg];
    assign s_tready  = (state_reg == ST_IDLE);
    assign h_we      = s_tvalid && s_tready;
    assign h_waddr   = pos_reg[HW-1:0];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign sum_b     = {1'b0, shift_reg} + {1'b0, hi_reg[b_sel_reg]};
    assign b_off     = idx_reg - shift_reg;
    assign poly_wbit = (c_mask_reg & c_rd) ^ (b_valid_reg & (b_one_reg | b_rd));

    // Update length: the larger of deg C and shift + deg B, capped.
    always_comb begin
        if (sum_b > (AW + 1)'(MAX_BLOCK)) begin
            top_calc = AW'(MAX_BLOCK);
        end else if (sum_b[AW-1:0] > hi_reg[c_sel_reg]) begin
            top_calc = sum_b[AW-1:0];
        end else begin
            top_calc = hi_reg[c_sel_reg];
        end
    end

    // Sequencer for the discrepancy and update loops.
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        lc_next      = lc_reg;
        shift_next   = shift_reg;
        for (int k = 0; k < 3; k++) begin
            hi_next[k] = hi_reg[k];
        end
        c_sel_next   = c_sel_reg;
        b_sel_next   = b_sel_reg;
        s_sel_next   = s_sel_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        top_next     = top_reg;
        wr_idx_next  = wr_idx_reg;
        acc_next     = acc_reg;
        rd_v_next    = 1'b0;
        c_mask_next  = c_mask_reg;
        b_valid_next = b_valid_reg;
        b_one_next   = b_one_reg;
        c_addr       = idx_reg;
        b_addr       = b_off;
        h_raddr      = HW'(pos_reg - idx_reg);
        poly_we      = 1'b0;
        restart      = 1'b0;
        hist_strobe  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    acc_next   = s_tdata[0];
                    idx_next   = AW'(1);
                    lim_next   = (lc_reg < pos_reg) ? lc_reg : pos_reg;
                    state_next = ST_DISC;
                end
            end
            ST_DISC: begin
                if (rd_v_reg) begin
                    acc_next = acc_reg ^ (c_mask_reg & c_rd & h_rdata);
                end
                if (idx_reg <= lim_reg) begin
                    rd_v_next   = 1'b1;
                    c_mask_next = (idx_reg <= hi_reg[c_sel_reg]);
                    idx_next    = idx_reg + 1'b1;
                end else if (!rd_v_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (acc_reg) begin
                    top_next   = top_calc;
                    idx_next   = AW'(1);
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_ADV;
                end
            end
            ST_UPDATE: begin
                poly_we = rd_v_reg;
                if (idx_reg <= top_reg) begin
                    rd_v_next    = 1'b1;
                    wr_idx_next  = idx_reg;
                    c_mask_next  = (idx_reg <= hi_reg[c_sel_reg]);
                    b_valid_next = (idx_reg >= shift_reg) && (b_off <= hi_reg[b_sel_reg]);
                    b_one_next   = (idx_reg == shift_reg);
                    idx_next     = idx_reg + 1'b1;
                end else if (!rd_v_reg) begin
                    hi_next[s_sel_reg] = top_reg;
                    c_sel_next = s_sel_reg;
                    if ({1'b0, lc_reg, 1'b0} <= {2'b00, pos_reg}) begin
                        // Complexity grows: the old C becomes B.
                        lc_next    = pos_reg + 1'b1 - lc_reg;
                        shift_next = '0;
                        b_sel_next = c_sel_reg;
                        s_sel_next = b_sel_reg;
                    end else begin
                        s_sel_next = c_sel_reg;
                    end
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                pos_next   = pos_reg + 1'b1;
                shift_next = shift_reg + 1'b1;
                state_next = (pos_reg + 1'b1 == len_used) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    hist_strobe = 1'b1;
                    restart     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new block starts with C = B = 1.
        if (restart || cfg_wr_en) begin
            pos_next   = '0;
            lc_next    = '0;
            shift_next = AW'(1);
            for (int k = 0; k < 3; k++) begin
                hi_next[k] = '0;
            end
            c_sel_next = 2'd0;
            b_sel_next = 2'd1;
            s_sel_next = 2'd2;
        end
        if (cfg_wr_en) begin
            state_next = ST_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_cfg_reg <= lcbt_pkg::LEN_RESET;
            pos_reg     <= '0;
            lc_reg      <= '0;
            shift_reg   <= AW'(1);
            for (int k = 0; k < 3; k++) begin
                hi_reg[k] <= '0;
            end
            c_sel_reg   <= 2'd0;
            b_sel_reg   <= 2'd1;
            s_sel_reg   <= 2'd2;
            rd_v_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                len_cfg_reg <= cfg_wr_data;
            end
            pos_reg   <= pos_next;
            lc_reg    <= lc_next;
            shift_reg <= shift_next;
            for (int k = 0; k < 3; k++) begin
                hi_reg[k] <= hi_next[k];
            end
            c_sel_reg <= c_sel_next;
            b_sel_reg <= b_sel_next;
            s_sel_reg <= s_sel_next;
            rd_v_reg  <= rd_v_next;
        end
    end

    // Loop datapath registers.
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        lim_reg     <= lim_next;
        top_reg     <= top_next;
        wr_idx_reg  <= wr_idx_next;
        acc_reg     <= acc_next;
        c_mask_reg  <= c_mask_next;
        b_valid_reg <= b_valid_next;
        b_one_reg   <= b_one_next;
    end

    // Output register: one result beat per finished block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (hist_strobe) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_strobe) begin
            m_tdata_reg <= {hres.blocks_done, hres.category_count, hres.category,
                            lcbt_pkg::LC_W'(lc_reg)};
        end
    end

endmodule

@@ hdl/lcbt_ram.sv @@
// ---------------------------------------------------------------------------
// lcbt_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module lcbt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/lcbt_hist.sv @@
// ---------------------------------------------------------------------------
// lcbt_hist: category rule and saturating histogram
// Maps a finished block's complexity to one of seven bins and keeps the bin
// counts and the block count.
// ---------------------------------------------------------------------------
module lcbt_hist #(
    parameter int AW = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  logic               strobe,
    input  logic [AW-1:0]      len,
    input  logic [AW-1:0]      lc,
    output lcbt_pkg::hist_res_t res
);

    localparam int SW = AW + 3;

    logic [lcbt_pkg::CNT_W-1:0] bin_reg [lcbt_pkg::NUM_BINS];
    logic [lcbt_pkg::CNT_W-1:0] blk_reg;
    logic signed [SW-1:0]       dev;
    logic [lcbt_pkg::CAT_W-1:0] cat;
    logic [lcbt_pkg::CNT_W-1:0] cur;

    // Integer form of the deviation statistic; half the length is a shift.
    always_comb begin
        if (len[0] == 1'b0) begin
            dev = $signed({3'b000, lc}) - $signed({4'b0000, len[AW-1:1]}) + SW'(3);
        end else begin
            dev = $signed({4'b0000, len[AW-1:1]}) - $signed({3'b000, lc}) + SW'(4);
        end
        if (dev < 0) begin
            cat = '0;
        end else if (dev > SW'(lcbt_pkg::CAT_TOP)) begin
            cat = lcbt_pkg::CAT_TOP;
        end else begin
            cat = dev[lcbt_pkg::CAT_W-1:0];
        end
        cur = bin_reg[cat];
        res.category       = cat;
        res.category_count = (cur == lcbt_pkg::CNT_MAX) ? cur : cur + 1'b1;
        res.blocks_done    = (blk_reg == lcbt_pkg::CNT_MAX) ? blk_reg : blk_reg + 1'b1;
    end

    // Counts advance on each finished block and saturate.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int k = 0; k < lcbt_pkg::NUM_BINS; k++) begin
                bin_reg[k] <= '0;
            end
            blk_reg <= '0;
        end else if (strobe) begin
            bin_reg[cat] <= res.category_count;
            blk_reg      <= res.blocks_done;
        end
    end

endmodule

@@ hdl/lcbt_checker.sv @@
// ---------------------------------------------------------------------------
// lcbt_checker: port-level checks for the linear complexity tester
// Watches the top level's ports and is bound to every instance of it.
// ---------------------------------------------------------------------------
module lcbt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wr_en,
    input logic [lcbt_pkg::CFG_W-1:0]    cfg_wr_data,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lcbt_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lcbt_pkg::M_DATA_W-1:0] m_tdata
);

    // No result is pending right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // The bin lies in range and its count never exceeds the block count.
    a_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:13] <= lcbt_pkg::CAT_TOP)
                  && (m_tdata[31:16] <= m_tdata[47:32]) && (m_tdata[47:32] != 16'd0))
        else $error("inconsistent category or counts");

    // An accepted bit takes the block out of its ready state, unless a length write comes with it.
    a_serial: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !cfg_wr_en |=> !s_tready)
        else $error("input beat accepted while a bit is in work");

endmodule

bind linear_complexity_block_tester lcbt_checker u_lcbt_checker (.*);

@@ test/linear_complexity_block_tester_tb.sv @@
// ---------------------------------------------------------------------------
// linear_complexity_block_tester_tb: self-checking bench for the block tester
// Streams bits through the input channel under random bursts and receiver
// stalls. A behavioral Berlekamp-Massey predictor keeps the expected
// complexity, bin and counts of every finished block, and each result beat
// is checked field by field against the oldest outstanding block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_complexity_block_tester_tb;

    localparam int MAX_BLOCK  = 4096;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        logic [lcbt_pkg::LC_W-1:0]  complexity;
        logic [lcbt_pkg::CAT_W-1:0] category;
        logic [lcbt_pkg::CNT_W-1:0] category_count;
        logic [lcbt_pkg::CNT_W-1:0] blocks_done;
    } block_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [lcbt_pkg::CFG_W-1:0]      cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lcbt_pkg::S_DATA_W-1:0]   s_tdata = '0;    // [0] bit_value, rest zero
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lcbt_pkg::M_DATA_W-1:0]   m_tdata;         // [12:0] complexity, [15:13] bin,
                                                      // [31:16] bin count, [47:32] blocks

    linear_complexity_block_tester #(.MAX_BLOCK(MAX_BLOCK)) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Predictor state of the Berlekamp-Massey engine and the histogram.
    logic [lcbt_pkg::CFG_W-1:0] len_reg;
    bit               conn_poly [0:MAX_BLOCK];
    bit               prev_poly [0:MAX_BLOCK];
    bit               saved_poly[0:MAX_BLOCK];
    bit               seq_bits  [0:MAX_BLOCK-1];
    int               cur_lc;
    int               change_pos;
    int               bit_pos;
    int               bin_tally[lcbt_pkg::NUM_BINS];
    int               block_tally;

    block_result_t    results_due[$];
    int               mismatches = 0;
    int               burst_left = 0;
    int               stall_hold = 0;

    function automatic int active_length();
        if (len_reg < 2) return 2;
        if (len_reg > MAX_BLOCK) return MAX_BLOCK;
        return int'(len_reg);
    endfunction

    function automatic int bin_for(int len, int lc);
        int v;
        if (len % 2 == 0) v = lc - len / 2 + 3;
        else v = (len - 1) / 2 - lc + 4;
        if (v < 0) v = 0;
        if (v > lcbt_pkg::NUM_BINS - 1) v = lcbt_pkg::NUM_BINS - 1;
        return v;
    endfunction

    task automatic restart_block();
        for (int i = 0; i <= MAX_BLOCK; i++) begin
            conn_poly[i] = 1'b0;
            prev_poly[i] = 1'b0;
        end
        conn_poly[0] = 1'b1;
        prev_poly[0] = 1'b1;
        cur_lc = 0;
        change_pos = -1;
        bit_pos = 0;
    endtask

    // One Berlekamp-Massey step; a finished block queues its expected result.
    task automatic absorb_bit(bit b);
        int            len;
        int            n;
        int            shift;
        int            cat;
        bit            d;
        block_result_t r;
        len = active_length();
        n = bit_pos;
        if (n >= len) begin
            restart_block();
            n = 0;
        end
        seq_bits[n] = b;
        d = b;
        for (int i = 1; i <= cur_lc && i <= n; i++)
            d ^= conn_poly[i] & seq_bits[n - i];
        if (d) begin
            saved_poly = conn_poly;
            shift = n - change_pos;
            for (int i = 0; i + shift <= MAX_BLOCK; i++)
                conn_poly[i + shift] ^= prev_poly[i];
            if (cur_lc <= n / 2) begin
                cur_lc = n + 1 - cur_lc;
                change_pos = n;
                prev_poly = saved_poly;
            end
        end
        bit_pos = n + 1;
        if (bit_pos >= len) begin
            cat = bin_for(len, cur_lc);
            if (bin_tally[cat] < 65535) bin_tally[cat]++;
            if (block_tally < 65535) block_tally++;
            r.complexity     = lcbt_pkg::LC_W'(cur_lc);
            r.category       = lcbt_pkg::CAT_W'(cat);
            r.category_count = lcbt_pkg::CNT_W'(bin_tally[cat]);
            r.blocks_done    = lcbt_pkg::CNT_W'(block_tally);
            results_due.push_back(r);
            restart_block();
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge aclk) begin
        block_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                r = results_due.pop_front();
                if (m_tdata[12:0] !== r.complexity)
                    report_mismatch("complexity", int'(m_tdata[12:0]), int'(r.complexity));
                if (m_tdata[15:13] !== r.category)
                    report_mismatch("category", int'(m_tdata[15:13]), int'(r.category));
                if (m_tdata[31:16] !== r.category_count)
                    report_mismatch("category_count", int'(m_tdata[31:16]),
                                    int'(r.category_count));
                if (m_tdata[47:32] !== r.blocks_done)
                    report_mismatch("blocks_done", int'(m_tdata[47:32]),
                                    int'(r.blocks_done));
            end
        end
    end

    // Receiver: stall pattern redrawn when the phase counter wraps, long hold on request.
    always @(negedge aclk) begin
        int phase;
        int mode;
        if (stall_hold > 0) begin
            stall_hold--;
            m_tready <= 1'b0;
        end else begin
            phase = (phase + 1) % 64;
            if (phase == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet);
            $display("linear_complexity_block_tester verification failed");
            $finish;
        end
    end

    // Sends one bit beat, inserting bursts and gaps on the way.
    task automatic send_bit(bit b);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {{(lcbt_pkg::S_DATA_W-1){1'b0}}, b};
        do @(posedge aclk); while (!s_tready);
        absorb_bit(b);
        @(negedge aclk);
    endtask

    task automatic wait_results_done();
        s_tvalid = 1'b0;
        wait (results_due.size() == 0);
        @(negedge aclk);
    endtask

    // Register write once the block is idle; a partial block may still run.
    task automatic write_length(int value);
        int settle;
        wait_results_done();
        settle = 4 * active_length() + 40;
        repeat (settle) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = lcbt_pkg::CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        len_reg     = lcbt_pkg::CFG_W'(value);
        restart_block();
    endtask

    // Produces one bit of a block according to a content style.
    function automatic bit pattern_bit(int style, int idx, int period, int seed);
        case (style)
            0: return 1'b0;
            1: return 1'b1;
            2: return seed[idx % period];
            default: return bit'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_block(int len, int style);
        int period;
        int seed;
        period = $urandom_range(1, 8);
        seed = $urandom;
        for (int i = 0; i < len; i++) send_bit(pattern_bit(style, i, period, seed));
    endtask

    // Directed: smallest lengths, odd and even, clamped lengths.
    task automatic test_directed();
        write_length(2);
        send_bit(0); send_bit(0);
        send_bit(0); send_bit(1);
        send_bit(1); send_bit(0);
        send_bit(1); send_bit(1);
        write_length(3);
        send_block(3, 0);
        send_bit(0); send_bit(0); send_bit(1);
        send_bit(1); send_bit(0); send_bit(1);
        write_length(0);
        send_bit(1); send_bit(1);
        write_length(1);
        send_bit(0); send_bit(1);
        // A partial block is thrown away by the next length write.
        write_length(8191);
        send_bit(1); send_bit(0); send_bit(1);
        write_length(MAX_BLOCK);
        send_bit(0); send_bit(1);
    endtask

    // Long receiver hold while the sender keeps offering short blocks.
    task automatic test_backpressure();
        write_length(2);
        stall_hold = 3000;
        for (int i = 0; i < 40; i++) send_bit(bit'($urandom_range(0, 1)));
        wait_results_done();
    endtask

    // Random block lengths and contents, mostly whole blocks.
    task automatic test_random(int budget);
        int sent;
        int len;
        int cut;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(25, 64);
                1: len = $urandom_range(2, 3);
                default: len = $urandom_range(2, 24);
            endcase
            write_length(len);
            repeat ($urandom_range(1, 4)) begin
                send_block(len, $urandom_range(0, 5));
                sent += len;
            end
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, len);
                for (int i = 0; i < cut; i++) send_bit(bit'($urandom_range(0, 1)));
                sent += cut;
            end
        end
    endtask

    // Larger block of 128 bits, run only once.
    task automatic test_long_block();
        write_length(128);
        send_block(128, 3);
        wait_results_done();
    endtask

    initial begin
        len_reg = lcbt_pkg::LEN_RESET;
        for (int i = 0; i < lcbt_pkg::NUM_BINS; i++) bin_tally[i] = 0;
        block_tally = 0;
        restart_block();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Bits under the reset length, then dropped by the first write.
        send_bit(1); send_bit(0); send_bit(1);
        test_directed();
        test_backpressure();
        test_random(330);
        test_long_block();

        wait_results_done();
        repeat (4 * active_length() + 40) @(negedge aclk);
        if (mismatches == 0) begin
            $display("linear_complexity_block_tester verification clean");
        end else begin
            $display("linear_complexity_block_tester verification failed");
        end
        $finish;
    end

endmodule
